FILE: hw/rtl/tlgb_pkg.sv
`timescale 1ns / 1ps

package tlgb_pkg;

  // Font store and framebuffer geometry.
  localparam int FONT_BYTES    = 2400;
  localparam int GLYPH_BYTES   = 25;
  localparam int GLYPH_COLUMNS = 12;
  localparam int LINE_WIDTH    = 128;

  localparam int FONT_AW     = $clog2(FONT_BYTES);
  localparam int FB_AW       = 9;
  localparam int COL_W       = $clog2(GLYPH_COLUMNS + 1);
  localparam int UPPER_W     = 9;
  localparam int LOWER_W     = 10;
  localparam int GLYPH_COUNT = FONT_BYTES / GLYPH_BYTES;

  // Character codes start at the space character.
  localparam logic [7:0] FIRST_CODE = 8'd32;

  // Last cursor positions accepted for a draw, leaving the final column of the line unused.
  localparam logic [UPPER_W-1:0] UPPER_LIMIT = UPPER_W'(LINE_WIDTH - GLYPH_COLUMNS - 1);
  localparam logic [LOWER_W-1:0] LOWER_LIMIT = LOWER_W'(3 * LINE_WIDTH - GLYPH_COLUMNS - 1);
  localparam logic [LOWER_W-1:0] LOWER_HOME  = LOWER_W'(2 * LINE_WIDTH);

  // Request codes.
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_RESTART = 2'd1;
  localparam logic [1:0] REQ_DRAW    = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DRAW,
    S_WIDTH,
    S_UPDATE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic restart;
    logic start;
    logic issue;
    logic emit;
    logic read_width;
    logic update;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic draw_ok;
    logic pending;
    logic out_free;
    logic all_issued;
  } status_t;

endpackage

FILE: hw/rtl/tlgb_if.sv
`timescale 1ns / 1ps

// Request channel: font loads, cursor restarts and characters to draw.
interface tlgb_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [tlgb_pkg::FONT_AW-1:0]  font_addr;
  logic [7:0]                    font_byte;
  logic [7:0]                    char_code;
  logic                          line_sel;

  modport source (output valid, req_type, font_addr, font_byte, char_code, line_sel,
                  input ready);
  modport sink   (input valid, req_type, font_addr, font_byte, char_code, line_sel,
                  output ready);
endinterface

// Framebuffer write channel.
interface tlgb_fb_if;
  logic                        valid;
  logic                        ready;
  logic [tlgb_pkg::FB_AW-1:0]  fb_addr;
  logic [7:0]                  fb_byte;
  logic                        last_write;

  modport source (output valid, fb_addr, fb_byte, last_write, input ready);
  modport sink   (input valid, fb_addr, fb_byte, last_write, output ready);
endinterface

FILE: hw/rtl/tlgb_ctrl.sv
`timescale 1ns / 1ps

module tlgb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [1:0]        req_type,
  output logic              req_ready,
  input  tlgb_pkg::status_t st,
  output tlgb_pkg::cmd_t    cmd
);
  import tlgb_pkg::*;

  state_t state;
  state_t state_next;
  logic   slot_open;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The read register is free for a new read when its pending byte leaves this cycle or there is none.
  assign slot_open = !st.pending || (st.pending && st.out_free);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          case (req_type)
            REQ_LOAD: begin
              cmd.load = 1'b1;
            end
            REQ_RESTART: begin
              cmd.restart = 1'b1;
            end
            REQ_DRAW: begin
              if (st.draw_ok) begin
                cmd.start  = 1'b1;
                state_next = S_DRAW;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DRAW: begin
        cmd.emit  = st.pending && st.out_free;
        cmd.issue = !st.all_issued && slot_open;
        if (st.all_issued && slot_open) begin
          state_next = S_WIDTH;
        end
      end
      S_WIDTH: begin
        cmd.read_width = 1'b1;
        state_next     = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A beat is only pushed when the output register can take it.
  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> st.out_free)
    else $error("beat pushed into a full output register");

  // A new read never overwrites a byte that has not been passed on.
  assert property (@(posedge clk) disable iff (rst)
                   cmd.issue |-> (!st.pending || cmd.emit))
    else $error("font read overwrote a pending byte");

endmodule

FILE: hw/rtl/tlgb_datapath.sv
`timescale 1ns / 1ps

module tlgb_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  tlgb_pkg::cmd_t                cmd,
  output tlgb_pkg::status_t             st,
  input  logic [tlgb_pkg::FONT_AW-1:0]  font_addr,
  input  logic [7:0]                    font_byte,
  input  logic [7:0]                    char_code,
  input  logic                          line_sel,
  output logic                          fb_valid,
  input  logic                          fb_ready,
  output logic [tlgb_pkg::FB_AW-1:0]    fb_addr,
  output logic [7:0]                    fb_byte,
  output logic                          last_write
);
  import tlgb_pkg::*;

  logic [7:0]         font_mem [FONT_BYTES];
  logic [7:0]         rdata;
  logic               rd_en;
  logic [FONT_AW-1:0] rd_addr;

  logic [UPPER_W-1:0] upper_cursor;
  logic [LOWER_W-1:0] lower_cursor;

  logic [FONT_AW-1:0] base;
  logic [LOWER_W-1:0] cur;
  logic               line;
  logic [7:0]         glyph_idx;

  logic [COL_W-1:0]   iss_col;
  logic               iss_half;
  logic [COL_W-1:0]   rd_col;
  logic               rd_half;
  logic               pending;

  logic [UPPER_W:0]   upper_sum;
  logic [LOWER_W:0]   lower_sum;

  // Glyph checks on the request at the input: code inside the font, line not full.
  assign glyph_idx = char_code - FIRST_CODE;
  always_comb begin
    st.draw_ok = (char_code >= FIRST_CODE) &&
                 (FONT_AW'(glyph_idx) < FONT_AW'(GLYPH_COUNT)) &&
                 (line_sel ? (lower_cursor <= LOWER_LIMIT) : (upper_cursor <= UPPER_LIMIT));
    st.pending    = pending;
    st.out_free   = !fb_valid || fb_ready;
    st.all_issued = (iss_col == COL_W'(GLYPH_COLUMNS));
  end

  // Font store: one write or one registered read per cycle.
  assign rd_en   = cmd.issue || cmd.read_width;
  assign rd_addr = cmd.read_width ? base
                 : base + FONT_AW'(1) + FONT_AW'({iss_col, 1'b0}) + FONT_AW'(iss_half);

  always_ff @(posedge clk) begin
    if (cmd.load && (font_addr < FONT_AW'(FONT_BYTES))) begin
      font_mem[font_addr] <= font_byte;
    end
    if (rd_en) begin
      rdata <= font_mem[rd_addr];
    end
  end

  // Glyph base, cursor snapshot and line of the character being drawn.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      base <= FONT_AW'(glyph_idx * GLYPH_BYTES);
      cur  <= line_sel ? lower_cursor : LOWER_W'(upper_cursor);
      line <= line_sel;
    end
  end

  // Read sequencer: column index and half of the next byte and of the pending one.
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_col  <= '0;
      iss_half <= 1'b0;
      pending  <= 1'b0;
    end else begin
      if (cmd.start) begin
        iss_col  <= '0;
        iss_half <= 1'b0;
      end else if (cmd.issue) begin
        iss_half <= !iss_half;
        if (iss_half) begin
          iss_col <= iss_col + COL_W'(1);
        end
      end
      if (rd_en) begin
        pending <= 1'b1;
      end else if (cmd.emit || cmd.update) begin
        pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_col  <= iss_col;
      rd_half <= iss_half;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fb_valid <= 1'b0;
    end else if (cmd.emit) begin
      fb_valid <= 1'b1;
    end else if (fb_ready) begin
      fb_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      fb_addr    <= FB_AW'(cur + LOWER_W'(rd_col) +
                           (rd_half ? LOWER_W'(LINE_WIDTH) : LOWER_W'(0)));
      fb_byte    <= rdata;
      last_write <= rd_half && (rd_col == COL_W'(GLYPH_COLUMNS - 1));
    end
  end

  // Cursors advance by the glyph width and saturate at the top of their range.
  assign upper_sum = {1'b0, upper_cursor} + (UPPER_W + 1)'(rdata);
  assign lower_sum = {1'b0, lower_cursor} + (LOWER_W + 1)'(rdata);

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      upper_cursor <= '0;
      lower_cursor <= LOWER_HOME;
    end else if (cmd.update) begin
      if (line) begin
        lower_cursor <= lower_sum[LOWER_W] ? '1 : lower_sum[LOWER_W-1:0];
      end else begin
        upper_cursor <= upper_sum[UPPER_W] ? '1 : upper_sum[UPPER_W-1:0];
      end
    end
  end

  // A started glyph record lies wholly inside the font store.
  assert property (@(posedge clk) disable iff (rst)
                   cmd.start |=> ((FONT_AW + 1)'(base) + (FONT_AW + 1)'(GLYPH_BYTES)
                                  <= (FONT_AW + 1)'(FONT_BYTES)))
    else $error("glyph record runs past the font store");

  // The final beat of a character leaves only after every column read went out.
  assert property (@(posedge clk) disable iff (rst)
                   (cmd.emit && rd_half && (rd_col == COL_W'(GLYPH_COLUMNS - 1)))
                   |-> st.all_issued)
    else $error("last beat sent before all column reads were issued");

endmodule

FILE: hw/rtl/two_line_glyph_blitter.sv
`timescale 1ns / 1ps

// Glyph blitter for a four-page monochrome framebuffer with two text lines.
// The req channel takes one beat per request: a font load writes one byte of
// the 2400-byte font store, a restart puts both text cursors home, and a draw
// renders one character on the line chosen by line_sel. A draw that fits
// produces 24 beats on the fb channel, the upper then lower byte of each of
// 12 columns, with last_write set on the final beat; a draw past the end of
// its line or outside the font produces none. After a draw is accepted, its
// first fb beat is read into the font read register and then moved to the
// output register. A draw occupies the block through the accept, a read of
// each column byte through the single read port of the font store, the pass
// of the last byte to the output, then the width fetch and the cursor update.
// req_ready stays low from the accept until the cursor update is done.
// When the receiver stalls, the output register holds its beat and the font
// reads pause with one byte kept in the read register; nothing is dropped.
// Reset clears the cursors (upper line at 0, lower line at 256) and the
// output valid; the font store keeps no reset value and must be loaded before
// any character that uses it is drawn.
module two_line_glyph_blitter (
  input logic       clk,
  input logic       rst,
  tlgb_req_if.sink  req,
  tlgb_fb_if.source fb
);
  import tlgb_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Sequencing of requests and read/write beats.
  tlgb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Font store, cursors and framebuffer write register.
  tlgb_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .font_addr  (req.font_addr),
    .font_byte  (req.font_byte),
    .char_code  (req.char_code),
    .line_sel   (req.line_sel),
    .fb_valid   (fb.valid),
    .fb_ready   (fb.ready),
    .fb_addr    (fb.fb_addr),
    .fb_byte    (fb.fb_byte),
    .last_write (fb.last_write)
  );

endmodule
